>>> sv/rft_pkg.sv
package rft_pkg;

    // Message buffer geometry
    localparam int MSG_DEPTH = 64;
    localparam int ADDR_W    = $clog2(MSG_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;

    // Rail count limits
    localparam int RAIL_MIN  = 2;
    localparam int RAIL_MAX  = 16;
    localparam int RAIL_W    = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_RAILS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = CFG_IDX_W'(1);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PERM,
        ST_EMIT_RD,
        ST_EMIT_LD
    } rft_state_t;

    // One step of the zigzag walk
    typedef struct packed {
        logic              valid;
        logic              done;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] idx;
    } gen_out_t;

    // Permute-pass control toward the buffers
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
    } perm_ctl_t;

endpackage

>>> sv/rft_addr_gen.sv
module rft_addr_gen (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rft_pkg::RAIL_W-1:0] rails_eff,
    input  logic [rft_pkg::CNT_W-1:0]  len,
    output rft_pkg::gen_out_t          gen_o
);
    import rft_pkg::*;

    logic              active_reg, active_next;
    logic [RAIL_W-1:0] nr_reg, nr_next;
    logic [RAIL_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  len_reg, len_next;

    logic [RAIL_W:0]   period;
    logic [RAIL_W:0]   k_dbl;
    logic [RAIL_W:0]   step;
    logic [CNT_W-1:0]  pos_sum;
    logic              edge_rail;
    logic              finish;
    logic              hit;

    // Step size of the zigzag on the current rail
    always_comb begin
        period    = {RAIL_W'(nr_reg - 1'b1), 1'b0};
        k_dbl     = {k_reg, 1'b0};
        edge_rail = (k_reg == '0) || (k_reg == RAIL_W'(nr_reg - 1'b1));
        if (edge_rail) begin
            step = period;
        end else if (phase_reg) begin
            step = k_dbl;
        end else begin
            step = period - k_dbl;
        end
        // shared position adder
        pos_sum = pos_reg + CNT_W'(step);
        finish  = active_reg && (j_reg == len_reg);
        hit     = active_reg && !finish && (pos_reg < len_reg);
    end

    // Walk rails top to bottom, each left to right
    always_comb begin
        active_next = active_reg;
        nr_next     = nr_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        j_next      = j_reg;
        len_next    = len_reg;
        if (start) begin
            active_next = 1'b1;
            nr_next     = rails_eff;
            k_next      = '0;
            pos_next    = '0;
            phase_next  = 1'b0;
            j_next      = '0;
            len_next    = len;
        end else if (finish) begin
            active_next = 1'b0;
        end else if (hit) begin
            pos_next   = pos_sum;
            phase_next = !phase_reg;
            j_next     = j_reg + 1'b1;
        end else if (active_reg) begin
            k_next     = k_reg + 1'b1;
            pos_next   = CNT_W'(RAIL_W'(k_reg + 1'b1));
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
        nr_reg    <= nr_next;
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        phase_reg <= phase_next;
        j_reg     <= j_next;
        len_reg   <= len_next;
    end

    assign gen_o.valid = hit;
    assign gen_o.done  = finish;
    assign gen_o.pos   = pos_reg[ADDR_W-1:0];
    assign gen_o.idx   = j_reg[ADDR_W-1:0];

endmodule

>>> sv/rft_perm_buf.sv
module rft_perm_buf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_we,
    input  logic [rft_pkg::ADDR_W-1:0] load_addr,
    input  logic [7:0]                 load_data,
    input  rft_pkg::perm_ctl_t         perm_i,
    input  logic                       emit_rd_en,
    input  logic [rft_pkg::ADDR_W-1:0] emit_addr,
    output logic [7:0]                 emit_data
);
    import rft_pkg::*;

    logic [7:0] store_mem [MSG_DEPTH];
    logic [7:0] result_mem [MSG_DEPTH];

    logic [7:0]        store_q_reg;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [7:0]        emit_q_reg;

    // Hold incoming message bytes
    always_ff @(posedge aclk) begin
        if (load_we) begin
            store_mem[load_addr] <= load_data;
        end
    end

    // Permute: read one source byte, write it in the following cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= perm_i.valid;
        end
        if (perm_i.valid) begin
            store_q_reg <= store_mem[perm_i.rd_addr];
            wr_addr_reg <= perm_i.wr_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            result_mem[wr_addr_reg] <= store_q_reg;
        end
    end

    // Read permuted message in order
    always_ff @(posedge aclk) begin
        if (emit_rd_en) begin
            emit_q_reg <= result_mem[emit_addr];
        end
    end

    assign emit_data = emit_q_reg;

endmodule

>>> sv/rail_fence_transposition_core.sv
// Channel | Ports                                  | Contents
// s_      | s_tvalid s_tready s_tdata[7:0] s_tlast | message byte in, last marker
// m_      | m_tvalid m_tready m_tdata[7:0] m_tlast | permuted byte, last, m_tuser[0]
//         | m_tuser[0]                             | overflow flag
// cfg_    | cfg_valid cfg_ready cfg_index cfg_data | 0 rails, 1 decrypt mode
//
// Bytes load at one per cycle while the block is in its load state.
// After the last byte the zigzag walker permutes n bytes through the message
// buffer into the result buffer, one position per cycle on a single shared
// adder, except on the cycles where it moves on to the next rail.
// Emit then takes each byte through a buffer read and an output register load.
// Reset (aresetn low, synchronous) clears counters, flags and output valid; rails reset to 2, mode to encrypt.
// A stalled output holds its item; input is refused until the last item is loaded.
module rail_fence_transposition_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rft_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] in_byte
    input  logic                              s_tlast,   // in_last
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,   // out_last
    output logic [0:0]                        m_tuser    // [0] overflow
);
    import rft_pkg::*;

    rft_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  emit_idx_reg, emit_idx_next;
    logic [RAIL_W-1:0] rails_reg;
    logic              dec_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    logic              s_accept;
    logic              room;
    logic              out_free;
    logic              out_load;
    logic              emit_last;
    logic              gen_start;
    logic              emit_rd_en;
    logic [RAIL_W-1:0] rails_eff;
    gen_out_t          gen;
    perm_ctl_t         perm;
    logic [7:0]        emit_data;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign room      = (count_reg < CNT_W'(MSG_DEPTH));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = (CNT_W'(emit_idx_reg + 1'b1) == count_reg);

    // Clamp the rail count
    always_comb begin
        if (rails_reg < RAIL_W'(RAIL_MIN)) begin
            rails_eff = RAIL_W'(RAIL_MIN);
        end else if (rails_reg > RAIL_W'(RAIL_MAX)) begin
            rails_eff = RAIL_W'(RAIL_MAX);
        end else begin
            rails_eff = rails_reg;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = ST_PERM;
                end
            end
            ST_PERM: begin
                if (gen.done) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_tready   = 1'b0;
        gen_start  = 1'b0;
        emit_rd_en = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready  = 1'b1;
                gen_start = s_tvalid && s_tlast;
            end
            ST_PERM: begin
            end
            ST_EMIT_RD: begin
                emit_rd_en = 1'b1;
            end
            ST_EMIT_LD: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Byte count, overflow flag and emit index
    always_comb begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        emit_idx_next = emit_idx_reg;
        if (s_accept) begin
            if (room) begin
                count_next = count_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (gen_start) begin
            emit_idx_next = '0;
        end
        if (out_load) begin
            emit_idx_next = emit_idx_reg + 1'b1;
            if (emit_last) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    // Output register
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            emit_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            emit_idx_reg <= emit_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_tdata_reg <= emit_data;
            m_tlast_reg <= emit_last;
            m_tuser_reg <= ovf_reg;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rails_reg <= RAIL_W'(RAIL_MIN);
            dec_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RAILS:   rails_reg <= cfg_data[RAIL_W-1:0];
                REG_DECRYPT: dec_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Route walker positions: encrypt gathers, decrypt scatters
    always_comb begin
        perm.valid   = gen.valid;
        perm.rd_addr = dec_reg ? gen.idx : gen.pos;
        perm.wr_addr = dec_reg ? gen.pos : gen.idx;
    end

    rft_addr_gen u_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (gen_start),
        .rails_eff (rails_eff),
        .len       (count_next),
        .gen_o     (gen)
    );

    rft_perm_buf u_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_we    (s_accept && room),
        .load_addr  (count_reg[ADDR_W-1:0]),
        .load_data  (s_tdata),
        .perm_i     (perm),
        .emit_rd_en (emit_rd_en),
        .emit_addr  (emit_idx_reg[ADDR_W-1:0]),
        .emit_data  (emit_data)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

>>> sv/rft_checker.sv
module rft_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready
);

    // Stalled item stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // Input closes after the last byte of a message
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last byte");

    // A new output item only appears while input is held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output item produced during load");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind rail_fence_transposition_core rft_checker u_rft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

>>> tb/rail_fence_transposition_core_test.sv
module rail_fence_transposition_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rft_pkg::*;

    // Indexes past the two defined registers; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } perm_byte_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [7:0] in_byte
    logic                  s_tlast = 1'b0; // in_last
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [7:0] out_byte
    logic                  m_tlast;        // out_last
    logic [0:0]            m_tuser;        // [0] overflow

    // Shadow of the block: registers, buffered message, pending results
    logic [RAIL_W-1:0] rails_reg = RAIL_W'(RAIL_MIN);
    logic              decrypt_reg = 1'b0;
    logic [7:0]        held_bytes[$];
    logic              overflow_pending = 1'b0;
    perm_byte_t        expected_bytes[$];

    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;
    int  sink_hold = 0;
    int  stall_left = 0;

    rail_fence_transposition_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Expand the held message into its zigzag-permuted result bytes
    function automatic void zigzag_permute();
        int nr;
        int period;
        int n;
        int j;
        int m;
        int order[MSG_DEPTH];
        logic [7:0] perm[MSG_DEPTH];
        perm_byte_t item;
        nr = rails_reg;
        if (nr < RAIL_MIN) nr = RAIL_MIN;
        if (nr > RAIL_MAX) nr = RAIL_MAX;
        period = 2 * (nr - 1);
        n = held_bytes.size();
        j = 0;
        // walk rails top to bottom, positions left to right
        for (int k = 0; k < nr; k++) begin
            for (int pos = 0; pos < n; pos++) begin
                m = pos % period;
                if (((m < nr) ? m : period - m) == k) begin
                    order[j] = pos;
                    j++;
                end
            end
        end
        for (j = 0; j < n; j++) begin
            if (decrypt_reg)
                perm[order[j]] = held_bytes[j];
            else
                perm[j] = held_bytes[order[j]];
        end
        for (j = 0; j < n; j++) begin
            item.data = perm[j];
            item.last = (j == n - 1);
            item.ovf  = overflow_pending;
            expected_bytes = {expected_bytes, item};
        end
    endfunction

    // Check results, track register writes, predict on accepted input items
    always @(posedge aclk) begin : scoreboard
        perm_byte_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %02h", m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  m_tdata, want.data));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("out_last got %b want %b",
                                                  m_tlast, want.last));
                    if (m_tuser[0] !== want.ovf)
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  m_tuser[0], want.ovf));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RAILS:   rails_reg = cfg_data;
                    REG_DECRYPT: decrypt_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (held_bytes.size() < MSG_DEPTH)
                    held_bytes = {held_bytes, s_tdata};
                else
                    overflow_pending = 1'b1;
                if (s_tlast) begin
                    zigzag_permute();
                    held_bytes.delete();
                    overflow_pending = 1'b0;
                end
            end
        end
    end

    // End the run when no channel moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("rail_fence_transposition_core_test: FAIL");
                $finish;
            end
        end
    end

    // Receiver: requested hold-off first, then random stalls, mostly short
    always @(posedge aclk) begin
        int r;
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (sink_idle_on) begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    stall_left = $urandom_range(1, 3);
                else if (r < 29)
                    stall_left = $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!src_idle_on || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), i == len - 1);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_mode(input bit decrypt);
        cfg_write(REG_DECRYPT, {4'($urandom), decrypt});
    endtask

    // Stop offering, wait for all results, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Reset settings: two rails, encrypt; single-byte messages and byte extremes
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0A, 1'b1);
        wait_idle();
    endtask

    // Rail counts below and above range, rails covering the whole message,
    // decrypt mode and writes to undefined indexes
    task automatic test_rail_limits();
        cfg_write(REG_UNUSED_2, 5'h1F);
        cfg_write(REG_UNUSED_3, 5'h01);
        cfg_write(REG_RAILS, 5'd0);
        send_byte(8'h2A, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
        cfg_write(REG_RAILS, 5'd1);
        cfg_write(REG_DECRYPT, 5'h1F);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'hFE, 1'b1);
        wait_idle();
        cfg_write(REG_RAILS, 5'd31);
        write_mode(1'b0);
        send_random_message(4);
        wait_idle();
        cfg_write(REG_RAILS, 5'd3);
        write_mode(1'b1);
        send_random_message(5);
        wait_idle();
    endtask

    // Messages past the buffer size: extra bytes dropped, last one included
    task automatic test_buffer_overflow();
        cfg_write(REG_RAILS, 5'($urandom_range(RAIL_MIN, RAIL_MAX)));
        write_mode(1'b0);
        send_random_message(MSG_DEPTH + 2);
        wait_idle();
        write_mode(1'b1);
        send_random_message(MSG_DEPTH + 1);
        // flag must clear for the next message
        send_random_message(3);
        wait_idle();
    endtask

    // Hold the receiver off while a full message and the next one are offered
    task automatic test_output_backpressure();
        cfg_write(REG_RAILS, 5'(RAIL_MAX));
        write_mode(1'b1);
        src_idle_on = 1'b0;
        sink_hold = 400;
        send_random_message(MSG_DEPTH);
        send_random_message(10);
        wait_idle();
        src_idle_on = 1'b1;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return $urandom_range(MSG_DEPTH + 1, MSG_DEPTH + 4);
        if (r < 6) return MSG_DEPTH;
        if (r < 20) return $urandom_range(17, 40);
        return $urandom_range(1, 16);
    endfunction

    // Phases of random settings, each followed by a few random messages
    task automatic test_random_traffic(input int budget);
        int sent;
        int r;
        int len;
        logic [RAIL_W-1:0] rails_pick;
        sent = 0;
        while (sent < budget) begin
            wait_idle();
            src_idle_on  = ($urandom_range(0, 4) != 0);
            sink_idle_on = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 9);
            case (r)
                0:       rails_pick = RAIL_W'(RAIL_MIN);
                1:       rails_pick = RAIL_W'(RAIL_MAX);
                2:       rails_pick = RAIL_W'($urandom_range(0, 1));
                3:       rails_pick = RAIL_W'($urandom_range(RAIL_MAX + 1, 31));
                default: rails_pick = RAIL_W'($urandom_range(RAIL_MIN, RAIL_MAX));
            endcase
            if ($urandom_range(0, 3) != 0)
                cfg_write(REG_RAILS, rails_pick);
            if ($urandom_range(0, 2) != 0)
                write_mode(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                cfg_write($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          5'($urandom));
            repeat ($urandom_range(1, 4)) begin
                len = pick_length();
                send_random_message(len);
                sent += len;
            end
        end
        wait_idle();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_rail_limits();
        test_buffer_overflow();
        test_output_backpressure();
        test_random_traffic(200);
        if (mismatch_count == 0)
            $display("rail_fence_transposition_core_test: PASS");
        else
            $display("rail_fence_transposition_core_test: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/rft_pkg.sv
sv/rft_addr_gen.sv
sv/rft_perm_buf.sv
sv/rail_fence_transposition_core.sv
sv/rft_checker.sv
tb/rail_fence_transposition_core_test.sv
